// File: sv/palette_slot_map_macros.svh
// Assertion helpers for the palette slot map. Each expects clk and rst_n in scope.
`ifndef PALETTE_SLOT_MAP_MACROS_SVH
`define PALETTE_SLOT_MAP_MACROS_SVH

// Same-cycle implication.
`define PALS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("palette slot map check failed");

// Next-cycle implication.
`define PALS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("palette slot map check failed");

`endif

// File: sv/pals_pkg.sv
`default_nettype none

package pals_pkg;

    localparam int PALS_SLOTS      = 16;
    localparam int PALS_MAX_COLORS = 256;

    localparam int COLOR_W = 10;
    localparam logic [COLOR_W-1:0] PERMILLE_MAX = 10'd1000;

    typedef enum logic [1:0] {
        CMD_SET  = 2'd0,
        CMD_FREE = 2'd1,
        CMD_READ = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        ST_NEW   = 2'd0,
        ST_HIT   = 2'd1,
        ST_FULL  = 2'd2,
        ST_EMPTY = 2'd3
    } status_t;

    function automatic logic [COLOR_W-1:0] clamp_permille(input logic [COLOR_W-1:0] v);
        clamp_permille = (v > PERMILLE_MAX) ? PERMILLE_MAX : v;
    endfunction

endpackage

`default_nettype wire

// File: sv/pals_ram.sv
`default_nettype none

module pals_ram #(
    parameter int WIDTH = 38,
    parameter int DEPTH = pals_pkg::PALS_SLOTS,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: sv/pals_free.sv
`default_nettype none

// Highest unused device index below the clamped color count.
module pals_free #(
    parameter int MAX_COLORS = pals_pkg::PALS_MAX_COLORS
) (
    input  wire logic [MAX_COLORS-1:0] used,
    input  wire logic [8:0]            num_colors,
    output logic      [7:0]            free_index
);

    logic [8:0] limit;
    logic       found;
    logic [7:0] idx;

    always_comb
    begin
        if (num_colors == 9'd0)
        begin
            limit = 9'd1;
        end
        else if (num_colors > 9'(MAX_COLORS))
        begin
            limit = 9'(MAX_COLORS);
        end
        else
        begin
            limit = num_colors;
        end
    end

    // later hits override, so the highest free index wins
    always_comb
    begin
        found = 1'b0;
        idx   = 8'd0;
        for (int i = 0; i < MAX_COLORS; i++)
        begin
            if (!used[i] && (9'(i) < limit))
            begin
                found = 1'b1;
                idx   = 8'(i);
            end
        end
    end

    assign free_index = found ? idx : 8'(limit - 9'd1);

endmodule

`default_nettype wire

// File: sv/palette_slot_map.sv
`default_nettype none

// Palette slot map: one command word per clock, busy is always low. A command
// accepted on start is registered, decoded and applied in the following cycle.
// Its result is driven for exactly one cycle: the command passes the input
// register and then the result register, whose done flag marks the result.
// The receiver cannot stall, so results must be captured when done
// is high. Set matches the device index against all filled slots in parallel
// and appends on a miss (status full when the table is full, nothing stored);
// free scans a used-index bitmap with a priority encoder; read returns a slot
// from the slot RAM. num_colors may be written only while no command is in
// flight; out-of-range values are clamped to 1..MAX_COLORS.
module palette_slot_map #(
    parameter int SLOTS      = pals_pkg::PALS_SLOTS,
    parameter int MAX_COLORS = pals_pkg::PALS_MAX_COLORS
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    // command side
    input  wire logic       start,
    output logic            busy,
    input  wire logic [1:0] cmd,
    input  wire logic [7:0] device_index,
    input  wire logic [3:0] slot,
    input  wire logic [9:0] red_in,
    input  wire logic [9:0] green_in,
    input  wire logic [9:0] blue_in,
    // config
    input  wire logic       cfg_we,
    input  wire logic [8:0] cfg_wdata,
    // result side
    output logic            done,
    output logic [1:0]      status,
    output logic [3:0]      slot_out,
    output logic [7:0]      device_index_out,
    output logic [9:0]      red_out,
    output logic [9:0]      green_out,
    output logic [9:0]      blue_out,
    output logic [4:0]      used_count
);

    import pals_pkg::*;

    localparam int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;  // slot address bits
    localparam int CW    = $clog2(SLOTS + 1);                // fill count bits
    localparam int IW    = $clog2(MAX_COLORS);               // bitmap index bits
    localparam int RGB_W = 3 * COLOR_W;
    localparam int RAM_W = 8 + RGB_W;                        // {device, r, g, b}

    // never stalls: one word per clock
    assign busy = 1'b0;

    logic accept;
    assign accept = start && !busy;

    // ---------------- configuration ----------------
    logic [8:0] num_colors_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_colors_reg <= 9'd16;
        end
        else if (cfg_we)
        begin
            num_colors_reg <= cfg_wdata;
        end
    end

    // ---------------- input register ----------------
    logic         in_vld_reg;
    cmd_t         cmd_reg;
    logic [7:0]   dev_reg;
    logic [3:0]   slot_reg;
    logic [9:0]   red_reg;
    logic [9:0]   green_reg;
    logic [9:0]   blue_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg   <= cmd_t'(cmd);
            dev_reg   <= device_index;
            slot_reg  <= slot;
            red_reg   <= red_in;
            green_reg <= green_in;
            blue_reg  <= blue_in;
        end
    end

    // ---------------- slot state ----------------
    // Device indices live in flops for the parallel match; a copy sits in the
    // slot RAM together with the color for reads.
    logic [7:0]            dev_map_reg [SLOTS];
    logic [CW-1:0]         filled_reg;
    logic [MAX_COLORS-1:0] used_reg;

    // RAM is addressed straight from the port, so read data lines up with the
    // input register. A write on that same edge is caught by the bypass.
    logic             ram_we;
    logic [SW-1:0]    ram_waddr;
    logic [RAM_W-1:0] ram_wdata;
    logic [RAM_W-1:0] ram_rdata;

    pals_ram #(
        .WIDTH (RAM_W),
        .DEPTH (SLOTS)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (SW'(slot)),
        .rdata (ram_rdata)
    );

    logic             byp_vld_reg;
    logic [SW-1:0]    byp_addr_reg;
    logic [RAM_W-1:0] byp_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byp_vld_reg <= 1'b0;
        end
        else
        begin
            byp_vld_reg <= ram_we;
        end
    end

    always_ff @(posedge clk)
    begin
        byp_addr_reg <= ram_waddr;
        byp_data_reg <= ram_wdata;
    end

    logic [RAM_W-1:0] rd_word;
    assign rd_word = (byp_vld_reg && (byp_addr_reg == SW'(slot_reg))) ? byp_data_reg
                                                                      : ram_rdata;

    // ---------------- free index search ----------------
    logic [7:0] free_index;

    pals_free #(
        .MAX_COLORS (MAX_COLORS)
    ) u_free (
        .used       (used_reg),
        .num_colors (num_colors_reg),
        .free_index (free_index)
    );

    // ---------------- command execution ----------------
    logic          hit;
    logic [SW-1:0] hit_idx;
    logic          full;
    logic          append;
    logic [9:0]    red_c;
    logic [9:0]    green_c;
    logic [9:0]    blue_c;

    always_comb
    begin
        hit     = 1'b0;
        hit_idx = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (!hit && (i < int'(filled_reg)) && (dev_map_reg[i] == dev_reg))
            begin
                hit     = 1'b1;
                hit_idx = SW'(i);
            end
        end
    end

    assign full    = (filled_reg == CW'(SLOTS));
    assign red_c   = clamp_permille(red_reg);
    assign green_c = clamp_permille(green_reg);
    assign blue_c  = clamp_permille(blue_reg);

    logic          set_ok;
    assign set_ok = in_vld_reg && (cmd_reg == CMD_SET) && (hit || !full);
    assign append = set_ok && !hit;

    assign ram_we    = set_ok;
    assign ram_waddr = hit ? hit_idx : filled_reg[SW-1:0];
    assign ram_wdata = {dev_reg, red_c, green_c, blue_c};

    logic [CW-1:0] filled_next;
    assign filled_next = append ? (filled_reg + CW'(1)) : filled_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filled_reg <= '0;
            used_reg   <= '0;
        end
        else if (append)
        begin
            filled_reg <= filled_next;
            if (9'(dev_reg) < 9'(MAX_COLORS))
            begin
                used_reg[dev_reg[IW-1:0]] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (append)
        begin
            dev_map_reg[filled_reg[SW-1:0]] <= dev_reg;
        end
    end

    // result word
    status_t    status_next;
    logic [3:0] slot_next;
    logic [7:0] dev_next;
    logic [9:0] red_next;
    logic [9:0] green_next;
    logic [9:0] blue_next;
    logic       rd_filled;

    assign rd_filled = (32'(slot_reg) < 32'(filled_reg));

    always_comb
    begin
        status_next = ST_NEW;
        slot_next   = 4'd0;
        dev_next    = 8'd0;
        red_next    = 10'd0;
        green_next  = 10'd0;
        blue_next   = 10'd0;
        unique case (cmd_reg)
            CMD_SET:
            begin
                if (hit || !full)
                begin
                    status_next = hit ? ST_HIT : ST_NEW;
                    slot_next   = 4'(ram_waddr);
                    dev_next    = dev_reg;
                    red_next    = red_c;
                    green_next  = green_c;
                    blue_next   = blue_c;
                end
                else
                begin
                    status_next = ST_FULL;
                end
            end
            CMD_FREE:
            begin
                dev_next = free_index;
            end
            CMD_READ:
            begin
                slot_next = slot_reg;
                if (rd_filled)
                begin
                    status_next = ST_HIT;
                    {dev_next, red_next, green_next, blue_next} = rd_word;
                end
                else
                begin
                    status_next = ST_EMPTY;
                end
            end
            default:
            begin
                // unknown command: only the fill count is reported
            end
        endcase
    end

    // ---------------- result register ----------------
    logic       done_reg;
    status_t    status_reg;
    logic [3:0] slot_out_reg;
    logic [7:0] dev_out_reg;
    logic [9:0] red_out_reg;
    logic [9:0] green_out_reg;
    logic [9:0] blue_out_reg;
    logic [4:0] used_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= in_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_vld_reg)
        begin
            status_reg     <= status_next;
            slot_out_reg   <= slot_next;
            dev_out_reg    <= dev_next;
            red_out_reg    <= red_next;
            green_out_reg  <= green_next;
            blue_out_reg   <= blue_next;
            used_count_reg <= 5'(filled_next);
        end
    end

    assign done             = done_reg;
    assign status           = status_reg;
    assign slot_out         = slot_out_reg;
    assign device_index_out = dev_out_reg;
    assign red_out          = red_out_reg;
    assign green_out        = green_out_reg;
    assign blue_out         = blue_out_reg;
    assign used_count       = used_count_reg;

    // ---------------- checks ----------------
`include "palette_slot_map_macros.svh"

    `PALS_ASSERT_NEXT(a_result_follows, in_vld_reg, done)
    `PALS_ASSERT_NEXT(a_no_spurious_result, !in_vld_reg, !done)
    `PALS_ASSERT_NOW(a_fill_bound, 1'b1, filled_reg <= CW'(SLOTS))
    `PALS_ASSERT_NOW(a_fill_step, filled_reg != $past(filled_reg),
                     filled_reg == $past(filled_reg) + CW'(1))
    `PALS_ASSERT_NOW(a_full_drop, done && (status == ST_FULL), used_count == 5'(SLOTS))

endmodule

`default_nettype wire
